// ----- hw/rtl/psched_pkg.sv -----
// shared types and constants for the periodic task scheduler
package psched_pkg;

   // table capacity, one slot is always left unused
   localparam int MAX_TASKS  = 16;
   localparam int CNT_W      = $clog2(MAX_TASKS);
   localparam int TICK_W     = 16;
   localparam int TASK_IDX_W = 4;

   // transaction codes on the request channel
   localparam logic [1:0] FUNC_TICK = 2'd0;
   localparam logic [1:0] FUNC_SCAN = 2'd1;
   localparam logic [1:0] FUNC_ADD  = 2'd2;

   // one task table entry
   typedef struct packed {
      logic [TICK_W-1:0] period;
      logic [TICK_W-1:0] last_run;
   } ent_type;

   // one result transaction
   typedef struct packed {
      logic [TASK_IDX_W-1:0] task_index;
      logic                  due;
      logic                  accepted;
      logic                  last;
   } rsp_type;

endpackage

// ----- hw/rtl/psched_mem.sv -----
// task table memory, one read and one write port, registered read data
module psched_mem (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [psched_pkg::CNT_W-1:0] rd_addr,
   output psched_pkg::ent_type    rd_data,
   input  logic                   wr_en,
   input  logic [psched_pkg::CNT_W-1:0] wr_addr,
   input  psched_pkg::ent_type    wr_data
);
   import psched_pkg::*;

   ent_type mem [MAX_TASKS];
   ent_type rd_data_ff;

   // synchronous read, data held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/psched_out.sv -----
// result output register on the rsp channel
module psched_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  psched_pkg::rsp_type load_data,
   output logic                busy,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [psched_pkg::TASK_IDX_W-1:0] rsp_task_index,
   output logic                rsp_due,
   output logic                rsp_accepted,
   output logic                rsp_last
);
   import psched_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // register stays full until the transaction is taken
   assign busy     = valid_ff && !rsp_ready;
   assign valid_in = load || busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_task_index = data_ff.task_index;
   assign rsp_due        = data_ff.due;
   assign rsp_accepted   = data_ff.accepted;
   assign rsp_last       = data_ff.last;

endmodule

// ----- hw/rtl/periodic_task_scheduler_core.sv -----
// Periodic task scheduler: a table of up to MAX_TASKS-1 periodic tasks kept in one
// synchronous memory of {period, last-run} words, plus a 16-bit wrapping tick counter.
// Any request waits while a scan is running; an add also waits while the result
// register is still full and not being taken. A scan whose counter has changed walks
// the stored tasks with one memory read per entry, the due task's new last-run time
// written back in the same cycle as its due check, and the walk holds while the
// result channel stalls; the last due task, if any, gives the final result. Each
// due task is reported one result late so that the final one can carry the last flag.
module periodic_task_scheduler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_period,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_task_index,
   output logic        rsp_due,
   output logic        rsp_accepted,
   output logic        rsp_last
);
   import psched_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EVAL  = 2'd1;
   localparam logic [1:0] S_FLUSH = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  pend_idx_ff, pend_idx_in;
   logic              pend_vld_ff, pend_vld_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [TICK_W-1:0] scanned_ff, scanned_in;

   logic              rd_en;
   logic [CNT_W-1:0]  rd_addr;
   ent_type           rd_data;
   logic              wr_en;
   logic [CNT_W-1:0]  wr_addr;
   ent_type           wr_data;

   logic              out_load;
   rsp_type           out_data;
   logic              out_busy;

   logic              req_accept;
   logic [CNT_W-1:0]  idx_nxt;
   logic [TICK_W-1:0] elapsed;
   logic              is_due;

   psched_mem u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   psched_out u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (out_load),
      .load_data      (out_data),
      .busy           (out_busy),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_task_index (rsp_task_index),
      .rsp_due        (rsp_due),
      .rsp_accepted   (rsp_accepted),
      .rsp_last       (rsp_last)
   );

   // only an add needs the result register free at acceptance
   assign req_ready  = (state_ff == S_IDLE) && (!out_busy || (req_func != FUNC_ADD));
   assign req_accept = req_valid && req_ready;

   // due check on the entry just read
   assign idx_nxt = idx_ff + CNT_W'(1);
   assign elapsed = tick_ff - rd_data.last_run;
   assign is_due  = elapsed >= rd_data.period;

   // sequencer: request decode, table walk, final result
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      pend_idx_in = pend_idx_ff;
      pend_vld_in = pend_vld_ff;
      tick_in     = tick_ff;
      scanned_in  = scanned_ff;
      rd_en       = 1'b0;
      rd_addr     = idx_ff;
      wr_en       = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = '{period: rd_data.period, last_run: tick_ff};
      out_load    = 1'b0;
      out_data    = '{task_index: TASK_IDX_W'(pend_idx_ff), due: 1'b1,
                      accepted: 1'b0, last: 1'b0};

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_func)
                  FUNC_TICK: begin
                     tick_in = tick_ff + TICK_W'(1);
                  end
                  FUNC_SCAN: begin
                     if (tick_ff != scanned_ff) begin
                        scanned_in = tick_ff;
                        if (count_ff != '0) begin
                           rd_en    = 1'b1;
                           rd_addr  = '0;
                           idx_in   = '0;
                           state_in = S_EVAL;
                        end
                     end
                  end
                  FUNC_ADD: begin
                     out_load = 1'b1;
                     if ((req_period == '0) || (count_ff == CNT_W'(MAX_TASKS - 1))) begin
                        out_data = '{task_index: '0, due: 1'b0, accepted: 1'b0,
                                     last: 1'b1};
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff;
                        wr_data  = '{period: req_period,
                                     last_run: tick_ff + TICK_W'(count_ff) + TICK_W'(1)};
                        count_in = count_ff + CNT_W'(1);
                        out_data = '{task_index: TASK_IDX_W'(count_ff), due: 1'b0,
                                     accepted: 1'b1, last: 1'b1};
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_EVAL: begin
            // hold here while a pending result cannot be handed on
            if (!(is_due && pend_vld_ff && out_busy)) begin
               if (is_due) begin
                  out_load    = pend_vld_ff;
                  wr_en       = 1'b1;
                  pend_idx_in = idx_ff;
                  pend_vld_in = 1'b1;
               end
               if (idx_nxt == count_ff) begin
                  state_in = S_FLUSH;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_nxt;
                  idx_in  = idx_nxt;
               end
            end
         end
         S_FLUSH: begin
            // last due task closes the scan
            out_data.last = 1'b1;
            if (!pend_vld_ff) begin
               state_in = S_IDLE;
            end else if (!out_busy) begin
               out_load    = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         idx_ff      <= '0;
         count_ff    <= '0;
         pend_vld_ff <= 1'b0;
         tick_ff     <= '0;
         scanned_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         count_ff    <= count_in;
         pend_vld_ff <= pend_vld_in;
         tick_ff     <= tick_in;
         scanned_ff  <= scanned_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
   end

`ifndef SYNTH
   // table never fills its spare slot
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_TASKS - 1))
      else $error("task count beyond capacity");

   // walk stays inside the stored tasks
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> (idx_ff < count_ff))
      else $error("scan index past task count");

   // no pending due task survives the end of a scan
   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_vld_ff)
      else $error("pending result left when idle");

   // a scan on a changed counter with stored tasks starts the walk
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_func == FUNC_SCAN) && (tick_ff != scanned_ff)
       && (count_ff != '0)) |=> (state_ff == S_EVAL) && (idx_ff == '0))
      else $error("scan did not start walk");
`endif

endmodule
